### rtl/grpc_pkg.sv
// Package for the grabber/platform register controller.
// Holds opcodes, control register indexes, servo angle tables and the
// result field struct shared by the RTL modules. No dependencies.
`default_nettype none

package grpc_pkg;

  localparam int NUM_GRABBERS = 6;

  // Item kinds carried on s_tuser
  typedef enum logic [1:0] {
    OP_SET_PTR = 2'd0,
    OP_WRITE   = 2'd1,
    OP_READ    = 2'd2,
    OP_TICK    = 2'd3
  } opcode_t;

  // Control register map
  typedef enum logic [2:0] {
    REG_GRAB_CLOSED = 3'd0,
    REG_ANGLE_SEL   = 3'd1,
    REG_AUTO_CLOSE  = 3'd2,
    REG_BARRIER     = 3'd3,
    REG_PLATFORM    = 3'd4
  } ctrl_reg_t;

  localparam int CTRL_REG_COUNT = 5;

  localparam logic [7:0] DRIVE_LEVEL_RESET = 8'd255;

  localparam logic [7:0] ANGLE_OPEN  [NUM_GRABBERS] = '{8'd164, 8'd170, 8'd152,
                                                        8'd164, 8'd170, 8'd152};
  localparam logic [7:0] ANGLE_PLANT [NUM_GRABBERS] = '{8'd135, 8'd139, 8'd122,
                                                        8'd135, 8'd139, 8'd122};
  localparam logic [7:0] ANGLE_CUP   [NUM_GRABBERS] = '{8'd150, 8'd155, 8'd140,
                                                        8'd150, 8'd155, 8'd140};

  // Fields of one result that come from the control registers
  typedef struct packed {
    logic [7:0] lift2_drive;
    logic       lift2_up;
    logic [7:0] lift1_drive;
    logic       lift1_up;
    logic [NUM_GRABBERS-1:0][7:0] servo_angle;
  } result_fields_t;

endpackage

`default_nettype wire

### rtl/grpc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none

module grpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/grpc_ctrl.sv
// Control registers 0..4 (grabber closed, angle select, auto-close, barrier, platform bits),
// tick update and decode of servo angles and motor drive. Uses grpc_pkg.
`default_nettype none

module grpc_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     accept,
  input  wire grpc_pkg::opcode_t        opcode,
  input  wire logic                     wr_ctrl,     // pointer is on a control register
  input  wire grpc_pkg::ctrl_reg_t      ctrl_index,
  input  wire logic [7:0]               write_data,
  input  wire logic [5:0]               barrier_raw,
  input  wire logic                     lift1_bottom_raw,
  input  wire logic                     lift1_top_raw,
  input  wire logic                     lift2_bottom_raw,
  input  wire logic                     lift2_top_raw,
  input  wire logic [7:0]               drive_level,
  output      logic [7:0]               rd_byte,     // current value at ctrl_index
  output      grpc_pkg::result_fields_t fields_next  // fields after this transaction
);

  logic [7:0] grab_closed, angle_sel, auto_close, barrier_bits, plat_bits;
  logic [7:0] grab_closed_next, angle_sel_next, auto_close_next;
  logic [7:0] barrier_bits_next, plat_bits_next;
  logic [5:0] bar;
  logic [5:0] fire;
  logic       reached1, reached2;

  always_comb begin
    case (ctrl_index)
      grpc_pkg::REG_GRAB_CLOSED: rd_byte = grab_closed;
      grpc_pkg::REG_ANGLE_SEL:   rd_byte = angle_sel;
      grpc_pkg::REG_AUTO_CLOSE:  rd_byte = auto_close;
      grpc_pkg::REG_BARRIER:     rd_byte = barrier_bits;
      grpc_pkg::REG_PLATFORM:    rd_byte = plat_bits;
      default:                   rd_byte = 8'd0;
    endcase
  end

  always_comb begin
    grab_closed_next  = grab_closed;
    angle_sel_next    = angle_sel;
    auto_close_next   = auto_close;
    barrier_bits_next = barrier_bits;
    plat_bits_next    = plat_bits;
    bar  = ~barrier_raw;
    fire = auto_close[5:0] & bar;
    if (accept) begin
      case (opcode)
        grpc_pkg::OP_WRITE: begin
          if (wr_ctrl) begin
            case (ctrl_index)
              grpc_pkg::REG_GRAB_CLOSED: grab_closed_next  = write_data;
              grpc_pkg::REG_ANGLE_SEL:   angle_sel_next    = write_data;
              grpc_pkg::REG_AUTO_CLOSE:  auto_close_next   = write_data;
              grpc_pkg::REG_BARRIER:     barrier_bits_next = write_data;
              grpc_pkg::REG_PLATFORM:    plat_bits_next    = write_data;
              default: ;
            endcase
          end
        end
        grpc_pkg::OP_TICK: begin
          barrier_bits_next = {barrier_bits[7:6], bar};
          // target bits 2 and 5 and the spare bits are kept
          plat_bits_next    = {plat_bits[7:5], ~lift2_top_raw, ~lift2_bottom_raw,
                               plat_bits[2], ~lift1_top_raw, ~lift1_bottom_raw};
          auto_close_next   = auto_close & ~{2'b00, fire};
          grab_closed_next  = grab_closed | {2'b00, fire};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grab_closed  <= 8'd0;
      angle_sel    <= 8'd0;
      auto_close   <= 8'd0;
      barrier_bits <= 8'd0;
      plat_bits    <= 8'd0;
    end else begin
      grab_closed  <= grab_closed_next;
      angle_sel    <= angle_sel_next;
      auto_close   <= auto_close_next;
      barrier_bits <= barrier_bits_next;
      plat_bits    <= plat_bits_next;
    end
  end

  // Decode from the updated register values
  always_comb begin
    for (int i = 0; i < grpc_pkg::NUM_GRABBERS; i++) begin
      if (grab_closed_next[i]) begin
        fields_next.servo_angle[i] = angle_sel_next[i] ? grpc_pkg::ANGLE_CUP[i]
                                                       : grpc_pkg::ANGLE_PLANT[i];
      end else begin
        fields_next.servo_angle[i] = grpc_pkg::ANGLE_OPEN[i];
      end
    end
    reached1 = plat_bits_next[2] ? plat_bits_next[1] : plat_bits_next[0];
    reached2 = plat_bits_next[5] ? plat_bits_next[4] : plat_bits_next[3];
    fields_next.lift1_up    = plat_bits_next[2];
    fields_next.lift1_drive = reached1 ? 8'd0 : drive_level;
    fields_next.lift2_up    = plat_bits_next[5];
    fields_next.lift2_drive = reached2 ? 8'd0 : drive_level;
  end

endmodule

`default_nettype wire

### rtl/grabber_platform_register_controller.sv
// Top level of the grabber/platform register controller.
// Depends on grpc_pkg, grpc_ram and grpc_ctrl.
//
// Usage:
//   s_* is the item stream. s_tuser carries the opcode (set pointer, write,
//   read, control tick); s_tdata carries address, write byte and the raw
//   active-low barrier and limit-switch samples. m_* returns exactly one
//   result transaction per input transaction, in order: read byte, six
//   servo angles, and direction/drive for the two platform motors.
//   cfg_we/cfg_wdata load drive_level (PWM duty while a motor moves);
//   write it only while the block is idle.
// Throughput and pipeline:
//   One transaction per cycle sustained while m_tready stays high. A result
//   passes through the middle stage, which waits for the registered read of
//   the storage RAM, and then the output register before it shows on m_tvalid.
// Reset (rst, synchronous): pointer, control registers and pipeline valids
//   clear; drive_level returns to 255. Storage entries read as zero until
//   written, tracked by one valid flop per entry, so no clearing pass.
// Stall: when m_tready is low the output register holds, the middle stage
//   holds its result, and s_tready drops once both are occupied.
`default_nettype none

module grabber_platform_register_controller #(
  parameter int REGISTER_COUNT = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input item stream
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  // [7:0] reg_address, [15:8] write_data, [21:16] barrier_raw,
  // [22] lift1_bottom_raw, [23] lift1_top_raw, [24] lift2_bottom_raw,
  // [25] lift2_top_raw, [31:26] zero
  input  wire logic [31:0] s_tdata,
  // [1:0] opcode
  input  wire logic [1:0]  s_tuser,
  // Result stream
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  // [7:0] read_data, [15:8]..[55:48] servo_angle_0..5, [56] lift1_up,
  // [64:57] lift1_drive, [65] lift2_up, [73:66] lift2_drive, [79:74] zero
  output      logic [79:0] m_tdata,
  // Configuration: drive_level
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata
);

  localparam int AW = $clog2(REGISTER_COUNT);

  // Input fields
  grpc_pkg::opcode_t opcode;
  logic [7:0] reg_address;
  logic [7:0] write_data;
  logic [5:0] barrier_raw;
  logic       lift1_bottom_raw, lift1_top_raw, lift2_bottom_raw, lift2_top_raw;

  assign opcode           = grpc_pkg::opcode_t'(s_tuser);
  assign reg_address      = s_tdata[7:0];
  assign write_data       = s_tdata[15:8];
  assign barrier_raw      = s_tdata[21:16];
  assign lift1_bottom_raw = s_tdata[22];
  assign lift1_top_raw    = s_tdata[23];
  assign lift2_bottom_raw = s_tdata[24];
  assign lift2_top_raw    = s_tdata[25];

  logic accept;
  logic a_move;

  // Configuration register
  logic [7:0] drive_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_level <= grpc_pkg::DRIVE_LEVEL_RESET;
    end else if (cfg_we) begin
      drive_level <= cfg_wdata;
    end
  end

  // Set-pointer addresses reduced modulo the store depth: constant table
  logic [AW-1:0] addr_wrap [256];

  for (genvar v = 0; v < 256; v++) begin : g_wrap
    assign addr_wrap[v] = AW'(v % REGISTER_COUNT);
  end

  // Address pointer
  logic [AW-1:0] ptr, ptr_next, ptr_inc;

  assign ptr_inc = (ptr == AW'(REGISTER_COUNT - 1)) ? '0 : ptr + AW'(1);

  always_comb begin
    ptr_next = ptr;
    if (accept) begin
      case (opcode)
        grpc_pkg::OP_SET_PTR: ptr_next = addr_wrap[reg_address];
        grpc_pkg::OP_WRITE:   ptr_next = ptr_inc;
        grpc_pkg::OP_READ:    ptr_next = ptr_inc;
        default:              ptr_next = ptr;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else begin
      ptr <= ptr_next;
    end
  end

  // Control registers live in flops; everything else in the RAM
  logic                     is_ctrl;
  grpc_pkg::ctrl_reg_t      ctrl_index;
  logic [7:0]               ctrl_rd_byte;
  grpc_pkg::result_fields_t fields_next;

  assign is_ctrl    = (ptr < AW'(grpc_pkg::CTRL_REG_COUNT));
  assign ctrl_index = grpc_pkg::ctrl_reg_t'(ptr[2:0]);

  grpc_ctrl u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .opcode           (opcode),
    .wr_ctrl          (is_ctrl),
    .ctrl_index       (ctrl_index),
    .write_data       (write_data),
    .barrier_raw      (barrier_raw),
    .lift1_bottom_raw (lift1_bottom_raw),
    .lift1_top_raw    (lift1_top_raw),
    .lift2_bottom_raw (lift2_bottom_raw),
    .lift2_top_raw    (lift2_top_raw),
    .drive_level      (drive_level),
    .rd_byte          (ctrl_rd_byte),
    .fields_next      (fields_next)
  );

  // General storage and per-entry written flags
  logic                      ram_we, ram_re;
  logic [7:0]                ram_rdata;
  logic [REGISTER_COUNT-1:0] written;

  assign ram_we = accept && (opcode == grpc_pkg::OP_WRITE);
  assign ram_re = accept && (opcode == grpc_pkg::OP_READ);

  grpc_ram #(
    .WIDTH (8),
    .DEPTH (REGISTER_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ptr),
    .wdata (write_data),
    .re    (ram_re),
    .raddr (ptr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (ram_we) begin
      written[ptr] <= 1'b1;
    end
  end

  // Middle stage: waits for the RAM read data
  logic                     a_valid;
  logic                     a_is_read;
  logic                     a_from_ctrl;
  logic                     a_written;
  logic [7:0]               a_ctrl_byte;
  grpc_pkg::result_fields_t a_fields;
  logic [7:0]               a_read_data;

  logic out_valid;

  assign a_move   = a_valid && (!out_valid || m_tready);
  assign s_tready = !a_valid || a_move;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_is_read   <= (opcode == grpc_pkg::OP_READ);
      a_from_ctrl <= is_ctrl;
      a_written   <= written[ptr];
      a_ctrl_byte <= ctrl_rd_byte;
      a_fields    <= fields_next;
    end
  end

  // Untouched storage entries read as zero; non-read items return zero
  always_comb begin
    if (!a_is_read) begin
      a_read_data = 8'd0;
    end else if (a_from_ctrl) begin
      a_read_data = a_ctrl_byte;
    end else if (a_written) begin
      a_read_data = ram_rdata;
    end else begin
      a_read_data = 8'd0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (a_move) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      m_tdata <= {6'd0,
                  a_fields.lift2_drive, a_fields.lift2_up,
                  a_fields.lift1_drive, a_fields.lift1_up,
                  a_fields.servo_angle,
                  a_read_data};
    end
  end

  assign m_tvalid = out_valid;

endmodule

`default_nettype wire
